// ----- src/dstg_pkg.sv -----
`default_nettype none

package dstg_pkg;

	localparam int KIND_W   = 2;
	localparam int PERIOD_W = 16;
	localparam int DUR_W    = 8;
	localparam int DAC_W    = 10;

	// two channel steps of up to 2047 each fit in 12 bits
	localparam int SUM_W    = 12;
	localparam int MIX_MAX  = 1023;

	localparam int COUNTER_BITS_DEF = 16;
	localparam int LEVEL_STEP_DEF   = 511;

	localparam int S_TDATA_W = 32;
	localparam int M_TDATA_W = 16;

	typedef enum logic [KIND_W-1:0] {
		KIND_TICK  = 2'd0,
		KIND_DUR   = 2'd1,
		KIND_START = 2'd2,
		KIND_STOP  = 2'd3
	} kind_t;

	// command seen by one channel
	typedef struct packed {
		kind_t                kind;
		logic                 hit;
		logic [PERIOD_W-1:0]  period;
		logic [DUR_W-1:0]     duration;
	} chan_cmd_t;

	// channel status back to the top level
	typedef struct packed {
		logic running;
		logic level_next;
		logic wrap;
	} chan_stat_t;

endpackage

`default_nettype wire

// ----- src/dstg_channel.sv -----
`default_nettype none

module dstg_channel #(
	parameter int COUNTER_BITS = dstg_pkg::COUNTER_BITS_DEF
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     step,
	input  wire dstg_pkg::chan_cmd_t cmd,
	output dstg_pkg::chan_stat_t    stat
);

	logic [COUNTER_BITS-1:0]     cnt_q, cnt_d;
	logic [COUNTER_BITS-1:0]     per_q, per_d;
	logic [dstg_pkg::DUR_W-1:0]  rem_q, rem_d;
	logic                        run_q, run_d;
	logic                        lvl_q, lvl_d;
	logic                        wrap;

	always_comb begin
		cnt_d = cnt_q;
		per_d = per_q;
		rem_d = rem_q;
		run_d = run_q;
		lvl_d = lvl_q;
		wrap  = 1'b0;
		unique case (cmd.kind)
			dstg_pkg::KIND_TICK: begin
				if (run_q) begin
					if (cnt_q == per_q) begin
						cnt_d = '0;
						lvl_d = !lvl_q;
						wrap  = 1'b1;
					end else begin
						// counter above period rolls over at all-ones
						cnt_d = cnt_q + COUNTER_BITS'(1);
					end
				end
			end
			dstg_pkg::KIND_DUR: begin
				if (cmd.hit && rem_q != '0) begin
					rem_d = rem_q - dstg_pkg::DUR_W'(1);
					if (rem_q == dstg_pkg::DUR_W'(1)) begin
						lvl_d = 1'b0;
						run_d = 1'b0;
					end
				end
			end
			dstg_pkg::KIND_START: begin
				if (cmd.hit) begin
					rem_d = cmd.duration;
					per_d = COUNTER_BITS'(cmd.period);
					run_d = 1'b1;
				end
			end
			dstg_pkg::KIND_STOP: begin
				if (cmd.hit) begin
					rem_d = '0;
					lvl_d = 1'b0;
					run_d = 1'b0;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			per_q <= '0;
			rem_q <= '0;
			run_q <= 1'b0;
			lvl_q <= 1'b0;
		end else if (step) begin
			cnt_q <= cnt_d;
			per_q <= per_d;
			rem_q <= rem_d;
			run_q <= run_d;
			lvl_q <= lvl_d;
		end
	end

	assign stat.running    = run_q;
	assign stat.level_next = lvl_d;
	assign stat.wrap       = wrap;

endmodule

`default_nettype wire

// ----- src/dstg_mixer.sv -----
`default_nettype none

module dstg_mixer #(
	parameter int LEVEL_STEP = dstg_pkg::LEVEL_STEP_DEF
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        step,
	input  wire dstg_pkg::chan_stat_t  stat0,
	input  wire dstg_pkg::chan_stat_t  stat1,
	output logic [dstg_pkg::DAC_W-1:0] mix
);

	logic [dstg_pkg::SUM_W-1:0] sum;
	logic [dstg_pkg::DAC_W-1:0] mix_q;

	always_comb begin
		sum = (stat0.level_next ? dstg_pkg::SUM_W'(LEVEL_STEP) : '0)
		    + (stat1.level_next ? dstg_pkg::SUM_W'(LEVEL_STEP) : '0);
	end

	// remix only when a channel toggled; a stop leaves the word alone
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mix_q <= '0;
		end else if (step && (stat0.wrap || stat1.wrap)) begin
			if (sum > dstg_pkg::SUM_W'(dstg_pkg::MIX_MAX))
				mix_q <= dstg_pkg::DAC_W'(dstg_pkg::MIX_MAX);
			else
				mix_q <= sum[dstg_pkg::DAC_W-1:0];
		end
	end

	assign mix = mix_q;

endmodule

`default_nettype wire

// ----- src/dual_square_tone_generator.sv -----
// Two-channel square-wave tone generator.
// Input stream (s_axis): tuser carries the item kind (prescaled tick, duration
// tick, start, stop); tdata carries channel, period and duration. Start loads
// a channel's period and duration and enables it; stop disables it and drops
// its level. Each prescaled tick advances both enabled counters and toggles a
// channel's level when its counter matches the period.
// Output stream (m_axis): one item per input item, with the mixed DAC word
// and both channel enable flags after that input has taken effect.
// An accepted item goes through the input register, then the channel state and
// output register, which are updated together.
// Throughput: one item per cycle unless m_axis stalls; the only path is the
// combinational channel update between input and state/output registers.
// Reset clears all counters, periods, durations, levels and the DAC word and
// empties both registers. When the receiver stalls, the output holds and
// one further item is taken into the input register; then s_axis_tready
// drops until the output is taken.
`default_nettype none

module dual_square_tone_generator #(
	parameter int COUNTER_BITS = dstg_pkg::COUNTER_BITS_DEF,
	parameter int LEVEL_STEP   = dstg_pkg::LEVEL_STEP_DEF
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               s_axis_tvalid,
	output logic                              s_axis_tready,
	input  wire [dstg_pkg::S_TDATA_W-1:0]     s_axis_tdata,  // channel, period[15:0], duration[7:0], zero pad
	input  wire [dstg_pkg::KIND_W-1:0]        s_axis_tuser,  // kind
	output logic                              m_axis_tvalid,
	input  wire                               m_axis_tready,
	output logic [dstg_pkg::M_TDATA_W-1:0]    m_axis_tdata   // dac_value[9:0], chan0_active, chan1_active, zero pad
);

	logic                              item_valid_s1;
	dstg_pkg::kind_t                   kind_s1;
	logic                              chan_s1;
	logic [dstg_pkg::PERIOD_W-1:0]     period_s1;
	logic [dstg_pkg::DUR_W-1:0]        duration_s1;
	logic                              out_valid_q;
	logic                              step;
	dstg_pkg::chan_cmd_t               cmd0, cmd1;
	dstg_pkg::chan_stat_t              stat0, stat1;
	logic [dstg_pkg::DAC_W-1:0]        mix;

	assign step          = item_valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !item_valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (s_axis_tready)
				item_valid_s1 <= s_axis_tvalid;
			if (step)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_s1     <= dstg_pkg::KIND_TICK;
			chan_s1     <= 1'b0;
			period_s1   <= '0;
			duration_s1 <= '0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			kind_s1     <= dstg_pkg::kind_t'(s_axis_tuser);
			chan_s1     <= s_axis_tdata[0];
			period_s1   <= s_axis_tdata[dstg_pkg::PERIOD_W:1];
			duration_s1 <= s_axis_tdata[dstg_pkg::PERIOD_W+dstg_pkg::DUR_W:dstg_pkg::PERIOD_W+1];
		end
	end

	always_comb begin
		cmd0.kind     = kind_s1;
		cmd0.hit      = !chan_s1;
		cmd0.period   = period_s1;
		cmd0.duration = duration_s1;
		cmd1          = cmd0;
		cmd1.hit      = chan_s1;
	end

	dstg_channel #(.COUNTER_BITS(COUNTER_BITS)) u_chan0 (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.cmd    (cmd0),
		.stat   (stat0)
	);

	dstg_channel #(.COUNTER_BITS(COUNTER_BITS)) u_chan1 (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.cmd    (cmd1),
		.stat   (stat1)
	);

	dstg_mixer #(.LEVEL_STEP(LEVEL_STEP)) u_mixer (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.stat0  (stat0),
		.stat1  (stat1),
		.mix    (mix)
	);

	// channel state and mix word only move on step, so they are the result register
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {
		(dstg_pkg::M_TDATA_W - dstg_pkg::DAC_W - 2)'(0),
		stat1.running,
		stat0.running,
		mix
	};

endmodule

`default_nettype wire

// ----- src/dstg_checker.sv -----
`default_nettype none

module dstg_checker #(
	parameter int LEVEL_STEP = dstg_pkg::LEVEL_STEP_DEF
) (
	input wire                            clk,
	input wire                            arst_n,
	input wire                            s_axis_tvalid,
	input wire                            s_axis_tready,
	input wire                            m_axis_tvalid,
	input wire                            m_axis_tready,
	input wire [dstg_pkg::M_TDATA_W-1:0]  m_axis_tdata
);

	localparam int TWO_STEP = (2 * LEVEL_STEP > dstg_pkg::MIX_MAX) ?
		dstg_pkg::MIX_MAX : 2 * LEVEL_STEP;

	// output side holds while stalled
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output changed while stalled");

	// input is only held off when the output is stuck
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without output backpressure");

	// DAC word is a sum of whole channel steps
	a_dac_legal: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |->
			m_axis_tdata[dstg_pkg::DAC_W-1:0] == dstg_pkg::DAC_W'(0) ||
			m_axis_tdata[dstg_pkg::DAC_W-1:0] == dstg_pkg::DAC_W'(LEVEL_STEP) ||
			m_axis_tdata[dstg_pkg::DAC_W-1:0] == dstg_pkg::DAC_W'(TWO_STEP))
		else $error("illegal DAC word");

	// an accepted item shows up at the output through the input and result registers when never stalled
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && m_axis_tready |=> ##1 m_axis_tvalid ||
			!$past(m_axis_tready))
		else $error("result missing after accepted item");

endmodule

bind dual_square_tone_generator dstg_checker #(.LEVEL_STEP(LEVEL_STEP)) u_dstg_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ----- sim/dual_square_tone_generator_tb.sv -----
`default_nettype none

module dual_square_tone_generator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD  = 8;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int RAND_ITEMS  = 1700;
	localparam int DIR_ROWS    = 25;

	// result word as it sits in m_axis_tdata[11:0]
	typedef struct packed {
		logic                       a1;
		logic                       a0;
		logic [dstg_pkg::DAC_W-1:0] dac;
	} tone_out_t;

	typedef struct packed {
		dstg_pkg::kind_t               kind;
		logic                          ch;
		logic [dstg_pkg::PERIOD_W-1:0] per;
		logic [dstg_pkg::DUR_W-1:0]    dur;
		logic                          typed;
		tone_out_t                     want;
	} stim_row_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           s_axis_tvalid = 1'b0;
	logic                           s_axis_tready;
	logic [dstg_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;
	logic [dstg_pkg::KIND_W-1:0]    s_axis_tuser = '0;
	logic                           m_axis_tvalid;
	logic                           m_axis_tready = 1'b0;
	logic [dstg_pkg::M_TDATA_W-1:0] m_axis_tdata;

	// predicted channel state
	logic [dstg_pkg::PERIOD_W-1:0] ch_count [2];
	logic [dstg_pkg::PERIOD_W-1:0] ch_match [2];
	logic [dstg_pkg::DUR_W-1:0]    ch_left [2];
	logic                          ch_run [2];
	logic                          ch_level [2];
	logic [dstg_pkg::DAC_W-1:0]    dac_mix;

	tone_out_t tone_expect_q [$];
	tone_out_t rx_want;
	int        err_cnt = 0;
	int        cycle_cnt = 0;
	int        burst_left = 1;
	bit        pace_off = 1'b0;
	bit        rx_free = 1'b0;
	int        rx_mode = 0;
	int        rx_left = 0;

	stim_row_t dir_table [DIR_ROWS] = '{
		// straight out of reset
		'{dstg_pkg::KIND_TICK,  1'b0, 16'h0000, 8'h00, 1'b1, 12'h000},
		// idle channel, zero count
		'{dstg_pkg::KIND_DUR,   1'b1, 16'h0000, 8'h00, 1'b1, 12'h000},
		'{dstg_pkg::KIND_STOP,  1'b0, 16'h0000, 8'h00, 1'b1, 12'h000},
		// period 0, play until stopped
		'{dstg_pkg::KIND_START, 1'b0, 16'h0000, 8'h00, 1'b1, 12'h400},
		'{dstg_pkg::KIND_TICK,  1'b0, 16'h0000, 8'h00, 1'b0, 12'h000},
		'{dstg_pkg::KIND_TICK,  1'b0, 16'h0000, 8'h00, 1'b0, 12'h000},
		// widest period and duration
		'{dstg_pkg::KIND_START, 1'b1, 16'hFFFF, 8'hFF, 1'b0, 12'h000},
		'{dstg_pkg::KIND_TICK,  1'b0, 16'h0000, 8'h00, 1'b0, 12'h000},
		'{dstg_pkg::KIND_TICK,  1'b0, 16'h0000, 8'h00, 1'b0, 12'h000},
		// reload below running count
		'{dstg_pkg::KIND_START, 1'b1, 16'h0001, 8'h02, 1'b0, 12'h000},
		'{dstg_pkg::KIND_TICK,  1'b0, 16'h0000, 8'h00, 1'b0, 12'h000},
		'{dstg_pkg::KIND_TICK,  1'b0, 16'h0000, 8'h00, 1'b0, 12'h000},
		'{dstg_pkg::KIND_TICK,  1'b0, 16'h0000, 8'h00, 1'b0, 12'h000},
		'{dstg_pkg::KIND_DUR,   1'b1, 16'h0000, 8'h00, 1'b0, 12'h000},
		// runs out, channel halts
		'{dstg_pkg::KIND_DUR,   1'b1, 16'h0000, 8'h00, 1'b0, 12'h000},
		'{dstg_pkg::KIND_DUR,   1'b1, 16'h0000, 8'h00, 1'b0, 12'h000},
		// restart keeps count and level
		'{dstg_pkg::KIND_START, 1'b0, 16'h0003, 8'h00, 1'b0, 12'h000},
		'{dstg_pkg::KIND_TICK,  1'b0, 16'h0000, 8'h00, 1'b0, 12'h000},
		'{dstg_pkg::KIND_TICK,  1'b0, 16'h0000, 8'h00, 1'b0, 12'h000},
		// DAC word holds
		'{dstg_pkg::KIND_STOP,  1'b0, 16'h0000, 8'h00, 1'b0, 12'h000},
		'{dstg_pkg::KIND_TICK,  1'b0, 16'h0000, 8'h00, 1'b0, 12'h000},
		'{dstg_pkg::KIND_START, 1'b1, 16'hAAAA, 8'h55, 1'b0, 12'h000},
		'{dstg_pkg::KIND_START, 1'b0, 16'h5555, 8'hAA, 1'b0, 12'h000},
		'{dstg_pkg::KIND_STOP,  1'b1, 16'h0000, 8'h00, 1'b0, 12'h000},
		'{dstg_pkg::KIND_STOP,  1'b0, 16'h0000, 8'h00, 1'b0, 12'h000}
	};

	dual_square_tone_generator u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("dual_square_tone_generator verification failed");
			$finish;
		end
	end

	task automatic tone_predict(input dstg_pkg::kind_t k, input logic ch,
			input logic [dstg_pkg::PERIOD_W-1:0] per,
			input logic [dstg_pkg::DUR_W-1:0] dur, output tone_out_t res);
		logic       wrapped;
		logic [11:0] sum;
		wrapped = 1'b0;
		case (k)
			dstg_pkg::KIND_TICK: begin
				for (int c = 0; c < 2; c++) begin
					if (ch_run[c]) begin
						if (ch_count[c] == ch_match[c]) begin
							ch_count[c] = '0;
							ch_level[c] = ~ch_level[c];
							wrapped = 1'b1;
						end else begin
							// above its period the count runs up to all ones and wraps silently
							ch_count[c] = ch_count[c] + 1'b1;
						end
					end
				end
				if (wrapped) begin
					sum = '0;
					if (ch_level[0]) sum += 12'(dstg_pkg::LEVEL_STEP_DEF);
					if (ch_level[1]) sum += 12'(dstg_pkg::LEVEL_STEP_DEF);
					dac_mix = (sum > 12'(dstg_pkg::MIX_MAX)) ?
						dstg_pkg::DAC_W'(dstg_pkg::MIX_MAX) : sum[dstg_pkg::DAC_W-1:0];
				end
			end
			dstg_pkg::KIND_DUR: begin
				if (ch_left[ch] != '0) begin
					ch_left[ch] = ch_left[ch] - 1'b1;
					if (ch_left[ch] == '0) begin
						ch_level[ch] = 1'b0;
						ch_run[ch] = 1'b0;
					end
				end
			end
			dstg_pkg::KIND_START: begin
				ch_left[ch] = dur;
				ch_match[ch] = per;
				ch_run[ch] = 1'b1;
			end
			default: begin
				ch_left[ch] = '0;
				ch_level[ch] = 1'b0;
				ch_run[ch] = 1'b0;
			end
		endcase
		res.a1 = ch_run[1];
		res.a0 = ch_run[0];
		res.dac = dac_mix;
	endtask

	// sender bursts: random length, random gap after each burst
	task automatic pace();
		if (!pace_off) begin
			burst_left--;
			if (burst_left <= 0) begin
				s_axis_tvalid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
				                                         : $urandom_range(1, 16);
			end
		end
	endtask

	task automatic send_item(input dstg_pkg::kind_t k, input logic ch,
			input logic [dstg_pkg::PERIOD_W-1:0] per, input logic [dstg_pkg::DUR_W-1:0] dur,
			input logic typed, input tone_out_t typed_want);
		tone_out_t pred;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {7'd0, dur, per, ch};
		s_axis_tuser <= k;
		do @(posedge clk); while (!s_axis_tready);
		tone_predict(k, ch, per, dur, pred);
		tone_expect_q.push_back(typed ? typed_want : pred);
		pace();
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (tone_expect_q.size() != 0) @(posedge clk);
	endtask

	// receiver: checks each result against the queue and picks a new random stall pattern when its countdown runs out
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (tone_expect_q.size() == 0) begin
				if (err_cnt < 10)
					$display("unexpected item: dac=%0d a0=%b a1=%b", m_axis_tdata[9:0],
						m_axis_tdata[10], m_axis_tdata[11]);
				err_cnt++;
			end else begin
				rx_want = tone_expect_q.pop_front();
				if (m_axis_tdata[9:0] !== rx_want.dac || m_axis_tdata[10] !== rx_want.a0 ||
						m_axis_tdata[11] !== rx_want.a1) begin
					if (err_cnt < 10)
						$display("mismatch: dac exp %0d got %0d, a0 exp %b got %b, a1 exp %b got %b",
							rx_want.dac, m_axis_tdata[9:0], rx_want.a0, m_axis_tdata[10],
							rx_want.a1, m_axis_tdata[11]);
					err_cnt++;
				end
			end
		end
		if (rx_left == 0) begin
			rx_mode <= $urandom_range(0, 3);
			rx_left <= 64;
		end else begin
			rx_left <= rx_left - 1;
		end
		m_axis_tready <= rx_free || rx_mode == 0 || ($urandom_range(0, 3) >= rx_mode);
	end

	initial begin
		dstg_pkg::kind_t               k;
		logic [dstg_pkg::PERIOD_W-1:0] per;
		logic [dstg_pkg::DUR_W-1:0]    dur;
		int                            r;

		for (int c = 0; c < 2; c++) begin
			ch_count[c] = '0;
			ch_match[c] = '0;
			ch_left[c] = '0;
			ch_run[c] = 1'b0;
			ch_level[c] = 1'b0;
		end
		dac_mix = '0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_table[i])
			send_item(dir_table[i].kind, dir_table[i].ch, dir_table[i].per, dir_table[i].dur,
				dir_table[i].typed, dir_table[i].want);
		drain();

		// counter above its period: park ch0 above a small period, then keep it
		// counting up silently with no idling on either side
		send_item(dstg_pkg::KIND_START, 1'b0, 16'hFFFF, 8'h00, 1'b0, '0);
		while (ch_count[0] < 16'd8)
			send_item(dstg_pkg::KIND_TICK, 1'b0, '0, '0, 1'b0, '0);
		send_item(dstg_pkg::KIND_START, 1'b0, 16'h0002, 8'h00, 1'b0, '0);
		send_item(dstg_pkg::KIND_START, 1'b1, 16'd100, 8'h00, 1'b0, '0);
		pace_off = 1'b1;
		rx_free = 1'b1;
		repeat (12) send_item(dstg_pkg::KIND_TICK, 1'b0, '0, '0, 1'b0, '0);
		pace_off = 1'b0;
		rx_free = 1'b0;
		drain();

		for (int n = 0; n < RAND_ITEMS; n++) begin
			r = $urandom_range(0, 99);
			if (r < 55) k = dstg_pkg::KIND_TICK;
			else if (r < 72) k = dstg_pkg::KIND_DUR;
			else if (r < 88) k = dstg_pkg::KIND_START;
			else k = dstg_pkg::KIND_STOP;
			// mostly short periods and durations so tones toggle and expire often
			per = ($urandom_range(0, 9) < 8) ? dstg_pkg::PERIOD_W'($urandom_range(0, 6))
			                                 : dstg_pkg::PERIOD_W'($urandom());
			r = $urandom_range(0, 9);
			if (r < 6) dur = dstg_pkg::DUR_W'($urandom_range(1, 12));
			else if (r < 8) dur = '0;
			else dur = dstg_pkg::DUR_W'($urandom());
			send_item(k, 1'($urandom_range(0, 1)), per, dur, 1'b0, '0);
			if (n % 500 == 499)
				drain();
		end

		drain();
		repeat (8) @(posedge clk);
		if (err_cnt == 0) begin
			$display("dual_square_tone_generator verification clean");
		end else begin
			$display("dual_square_tone_generator verification failed");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ----- filelist.f -----
src/dstg_pkg.sv
src/dstg_channel.sv
src/dstg_mixer.sv
src/dual_square_tone_generator.sv
src/dstg_checker.sv
sim/dual_square_tone_generator_tb.sv
